>>> sv/mpsm_pkg.sv
`default_nettype none
package mpsm_pkg;

  localparam int unsigned Nodes      = 1024;
  localparam int unsigned NodeW      = $clog2(Nodes);
  localparam int unsigned CountW     = NodeW + 1;
  localparam int unsigned Alpha      = 26;
  localparam int unsigned SymW       = 5;
  localparam int unsigned Patterns   = 256;
  localparam int unsigned IdW        = 8;
  localparam int unsigned HeadW      = IdW + 1;
  localparam int unsigned MaxLine    = 1024;
  localparam int unsigned DepW       = 11;
  localparam int unsigned MaxReports = 64;
  localparam int unsigned RepW       = 7;
  localparam int unsigned PosW       = 10;
  localparam int unsigned LineW      = 11;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_CAP  = 2'd2;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_ADD   = 3'd1,
    OP_END   = 3'd2,
    OP_BUILD = 3'd3,
    OP_MATCH = 3'd4,
    OP_NOP   = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [SymW-1:0]  symbol;
    logic [IdW-1:0]   pattern_id;
    logic [LineW-1:0] line_index;
    logic [PosW-1:0]  position;
    logic             line_start;
  } req_t;

  typedef struct packed {
    logic [IdW-1:0]  match_id;
    logic [PosW-1:0] start_row;
    logic [PosW-1:0] start_col;
    logic [PosW-1:0] end_row;
    logic [PosW-1:0] end_col;
    logic            valid_match;
    logic            last;
    logic [1:0]      status;
  } rsp_t;

  typedef struct packed {
    op_e  op;
    logic sym_ok;
    req_t req;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qhead_t;

  typedef logic [Alpha-1:0][NodeW-1:0] row_t;

  typedef enum logic [4:0] {
    S_RST, S_IDLE, S_DISP, S_ADD, S_ADD_NEW, S_END, S_END_RD, S_END_CHK,
    S_B_POP, S_B_U, S_B_ROW, S_B_C, S_B_F, S_B_FCHK,
    S_M_RD, S_M_CHK, S_M_T, S_M_H, S_M_LIST, S_M_EMIT, S_M_FIN
  } st_e;

  function automatic rsp_t ack(input logic [1:0] st);
    rsp_t r;
    r = '0;
    r.last = 1'b1;
    r.status = st;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/mpsm_front.sv
`default_nettype none
module mpsm_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire mpsm_pkg::req_t req_i,
  output mpsm_pkg::qhead_t    head_o,
  input  wire logic           pop_i
);

  mpsm_pkg::qent_t q_mem [2];
  logic            wr_q, wr_d, rd_q, rd_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push;
  logic            pop;
  mpsm_pkg::qent_t ent;

  always_comb begin
    ent.req = req_i;
    ent.sym_ok = (req_i.symbol < 5'(mpsm_pkg::Alpha));
    if (req_i.opcode <= 3'(mpsm_pkg::OP_MATCH)) begin
      ent.op = mpsm_pkg::op_e'(req_i.opcode);
    end else begin
      ent.op = mpsm_pkg::OP_NOP;
    end
  end

  assign busy = (cnt_q == 2'd2);
  assign push = start && !busy;
  assign pop = pop_i && (cnt_q != 2'd0);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.ent = q_mem[rd_q];

  always_comb begin
    wr_d = push ? ~wr_q : wr_q;
    rd_d = pop ? ~rd_q : rd_q;
    cnt_d = 2'(cnt_q + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/mpsm_back.sv
`default_nettype none
module mpsm_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire mpsm_pkg::qhead_t             head_i,
  output logic                              pop_o,
  input  wire logic [mpsm_pkg::LineW-1:0]   num_rows_i,
  output mpsm_pkg::rsp_t                    rsp_o,
  output logic                              rsp_strobe_o
);

  // trie rows, one per node
  mpsm_pkg::row_t                  child_mem [mpsm_pkg::Nodes];
  logic [mpsm_pkg::NodeW-1:0]      fail_mem  [mpsm_pkg::Nodes];
  logic [mpsm_pkg::HeadW-1:0]      head_mem  [mpsm_pkg::Nodes];
  logic [mpsm_pkg::DepW-1:0]       depth_mem [mpsm_pkg::Nodes];
  logic [mpsm_pkg::HeadW-1:0]      dup_mem   [mpsm_pkg::Patterns];
  logic [mpsm_pkg::DepW-1:0]       plen_mem  [mpsm_pkg::Patterns];
  logic [mpsm_pkg::NodeW-1:0]      bfs_mem   [mpsm_pkg::Nodes];

  mpsm_pkg::row_t             child_rd, child_wd;
  logic [mpsm_pkg::NodeW-1:0] child_ra, child_wa, fail_ra, fail_wa, fail_rd, fail_wd;
  logic                       child_we, fail_we;
  logic [mpsm_pkg::NodeW-1:0] head_ra, head_wa, depth_ra, depth_wa;
  logic [mpsm_pkg::HeadW-1:0] head_rd, head_wd;
  logic                       head_we, depth_we;
  logic [mpsm_pkg::DepW-1:0]  depth_rd, depth_wd;
  logic [mpsm_pkg::IdW-1:0]   dup_ra, dup_wa, plen_ra;
  logic [mpsm_pkg::HeadW-1:0] dup_rd, dup_wd;
  logic                       dup_we, plen_we;
  logic [mpsm_pkg::DepW-1:0]  plen_rd, plen_wd;
  logic [mpsm_pkg::NodeW-1:0] bfs_ra, bfs_wa, bfs_rd, bfs_wd;
  logic                       bfs_we;

  mpsm_pkg::st_e               state_q, state_d;
  mpsm_pkg::qent_t             cmd_q, cmd_d;
  logic [mpsm_pkg::NodeW-1:0]  cursor_q, cursor_d, match_q, match_d;
  logic [mpsm_pkg::CountW-1:0] ncount_q, ncount_d;
  logic                        failed_q, failed_d;
  logic [mpsm_pkg::Patterns-1:0] inuse_q, inuse_d;
  logic [mpsm_pkg::NodeW-1:0]  node_q, node_d, u_q, u_d, v_q, v_d;
  logic [mpsm_pkg::NodeW-1:0]  failu_q, failu_d, failt_q, failt_d;
  logic [mpsm_pkg::IdW-1:0]    ptr_q, ptr_d;
  logic [mpsm_pkg::SymW-1:0]   chr_q, chr_d;
  mpsm_pkg::row_t              row_q, row_d;
  logic [mpsm_pkg::CountW-1:0] bhead_q, bhead_d, btail_q, btail_d;
  logic [mpsm_pkg::HeadW-1:0]  h_q, h_d;
  logic [mpsm_pkg::RepW-1:0]   count_q, count_d;
  logic                        capped_q, capped_d;
  mpsm_pkg::rsp_t              pend_q, pend_d, rsp_q, rsp_d;
  logic                        strobe_q, strobe_d;

  logic [mpsm_pkg::NodeW-1:0]  add_nxt, chk_nxt, bc_v, fchk_r, mstart;
  logic [mpsm_pkg::DepW-1:0]   cur_depth;
  logic [mpsm_pkg::IdW-1:0]    h_id;
  logic [mpsm_pkg::PosW-1:0]   first, colv;
  logic [mpsm_pkg::HeadW-1:0]  id_plus;
  mpsm_pkg::rsp_t              rep;

  assign add_nxt = child_rd[cmd_q.req.symbol];
  assign chk_nxt = child_rd[cmd_q.req.symbol];
  assign fchk_r = child_rd[chr_q];
  assign bc_v = row_q[chr_q];
  // the root row of depth memory is never written
  assign cur_depth = (cursor_q == '0) ? '0 : depth_rd;
  assign h_id = h_q[mpsm_pkg::IdW-1:0] - 8'd1;
  assign id_plus = {1'b0, cmd_q.req.pattern_id} + 9'd1;
  assign mstart = cmd_q.req.line_start ? '0 : match_q;
  assign first = cmd_q.req.position - plen_rd[mpsm_pkg::PosW-1:0] + 10'd1;
  assign colv = 10'(cmd_q.req.line_index - num_rows_i);

  always_comb begin
    rep = '0;
    rep.match_id = ptr_q;
    rep.valid_match = 1'b1;
    rep.status = mpsm_pkg::ST_OK;
    if (cmd_q.req.line_index < num_rows_i) begin
      rep.start_row = cmd_q.req.line_index[mpsm_pkg::PosW-1:0];
      rep.start_col = first;
      rep.end_row = cmd_q.req.line_index[mpsm_pkg::PosW-1:0];
      rep.end_col = cmd_q.req.position;
    end else begin
      rep.start_row = first;
      rep.start_col = colv;
      rep.end_row = cmd_q.req.position;
      rep.end_col = colv;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mpsm_pkg::S_RST: state_d = mpsm_pkg::S_IDLE;
      mpsm_pkg::S_IDLE: begin
        if (head_i.valid) state_d = mpsm_pkg::S_DISP;
      end
      mpsm_pkg::S_DISP: begin
        case (cmd_q.op)
          mpsm_pkg::OP_ADD: begin
            if (cmd_q.sym_ok && !failed_q) state_d = mpsm_pkg::S_ADD;
            else state_d = mpsm_pkg::S_IDLE;
          end
          mpsm_pkg::OP_END: begin
            if (!failed_q && cursor_q != '0 && !inuse_q[cmd_q.req.pattern_id]) begin
              state_d = mpsm_pkg::S_END;
            end else begin
              state_d = mpsm_pkg::S_IDLE;
            end
          end
          mpsm_pkg::OP_BUILD: state_d = mpsm_pkg::S_B_POP;
          mpsm_pkg::OP_MATCH: begin
            if (cmd_q.sym_ok) state_d = mpsm_pkg::S_M_RD;
            else state_d = mpsm_pkg::S_IDLE;
          end
          default: state_d = mpsm_pkg::S_IDLE;
        endcase
      end
      mpsm_pkg::S_ADD: begin
        if (add_nxt == '0 && ncount_q != 11'(mpsm_pkg::Nodes)
            && cur_depth < 11'(mpsm_pkg::MaxLine)) begin
          state_d = mpsm_pkg::S_ADD_NEW;
        end else begin
          state_d = mpsm_pkg::S_IDLE;
        end
      end
      mpsm_pkg::S_ADD_NEW: state_d = mpsm_pkg::S_IDLE;
      mpsm_pkg::S_END: begin
        if (head_rd == '0) state_d = mpsm_pkg::S_IDLE;
        else state_d = mpsm_pkg::S_END_RD;
      end
      mpsm_pkg::S_END_RD: state_d = mpsm_pkg::S_END_CHK;
      mpsm_pkg::S_END_CHK: begin
        if (dup_rd != '0) state_d = mpsm_pkg::S_END_RD;
        else state_d = mpsm_pkg::S_IDLE;
      end
      mpsm_pkg::S_B_POP: begin
        if (bhead_q == btail_q) state_d = mpsm_pkg::S_IDLE;
        else state_d = mpsm_pkg::S_B_U;
      end
      mpsm_pkg::S_B_U: state_d = mpsm_pkg::S_B_ROW;
      mpsm_pkg::S_B_ROW: state_d = mpsm_pkg::S_B_C;
      mpsm_pkg::S_B_C: begin
        if (chr_q == 5'(mpsm_pkg::Alpha)) state_d = mpsm_pkg::S_B_POP;
        else if (bc_v != '0 && u_q != '0) state_d = mpsm_pkg::S_B_F;
      end
      mpsm_pkg::S_B_F: state_d = mpsm_pkg::S_B_FCHK;
      mpsm_pkg::S_B_FCHK: begin
        if (fchk_r != '0 || node_q == '0) state_d = mpsm_pkg::S_B_C;
        else state_d = mpsm_pkg::S_B_F;
      end
      mpsm_pkg::S_M_RD: state_d = mpsm_pkg::S_M_CHK;
      mpsm_pkg::S_M_CHK: begin
        if (chk_nxt != '0 || node_q == '0) state_d = mpsm_pkg::S_M_T;
        else state_d = mpsm_pkg::S_M_RD;
      end
      mpsm_pkg::S_M_T: begin
        if (node_q == '0) state_d = mpsm_pkg::S_M_FIN;
        else state_d = mpsm_pkg::S_M_H;
      end
      mpsm_pkg::S_M_H: state_d = mpsm_pkg::S_M_LIST;
      mpsm_pkg::S_M_LIST: begin
        if (h_q == '0) state_d = mpsm_pkg::S_M_T;
        else if (count_q == 7'(mpsm_pkg::MaxReports)) state_d = mpsm_pkg::S_M_FIN;
        else state_d = mpsm_pkg::S_M_EMIT;
      end
      mpsm_pkg::S_M_EMIT: state_d = mpsm_pkg::S_M_LIST;
      mpsm_pkg::S_M_FIN: state_d = mpsm_pkg::S_IDLE;
      default: state_d = mpsm_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_d = cmd_q;
    cursor_d = cursor_q;
    match_d = match_q;
    ncount_d = ncount_q;
    failed_d = failed_q;
    inuse_d = inuse_q;
    node_d = node_q;
    u_d = u_q;
    v_d = v_q;
    failu_d = failu_q;
    failt_d = failt_q;
    ptr_d = ptr_q;
    chr_d = chr_q;
    row_d = row_q;
    bhead_d = bhead_q;
    btail_d = btail_q;
    h_d = h_q;
    count_d = count_q;
    capped_d = capped_q;
    pend_d = pend_q;
    rsp_d = rsp_q;
    strobe_d = 1'b0;
    pop_o = 1'b0;

    child_ra = node_q;
    fail_ra = node_q;
    head_ra = node_q;
    depth_ra = cursor_q;
    dup_ra = h_id;
    plen_ra = h_id;
    bfs_ra = bhead_q[mpsm_pkg::NodeW-1:0];
    child_we = 1'b0;
    child_wa = '0;
    child_wd = '0;
    fail_we = 1'b0;
    fail_wa = v_q;
    fail_wd = '0;
    head_we = 1'b0;
    head_wa = ncount_q[mpsm_pkg::NodeW-1:0];
    head_wd = '0;
    depth_we = 1'b0;
    depth_wa = ncount_q[mpsm_pkg::NodeW-1:0];
    depth_wd = cur_depth + 11'd1;
    dup_we = 1'b0;
    dup_wa = cmd_q.req.pattern_id;
    dup_wd = '0;
    plen_we = 1'b0;
    plen_wd = depth_rd;
    bfs_we = 1'b0;
    bfs_wa = btail_q[mpsm_pkg::NodeW-1:0];
    bfs_wd = v_q;

    case (state_q)
      mpsm_pkg::S_RST: begin
        child_we = 1'b1;
      end
      mpsm_pkg::S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          cmd_d = head_i.ent;
        end
      end
      mpsm_pkg::S_DISP: begin
        child_ra = cursor_q;
        head_ra = cursor_q;
        case (cmd_q.op)
          mpsm_pkg::OP_CLEAR: begin
            child_we = 1'b1;
            ncount_d = 11'd1;
            cursor_d = '0;
            match_d = '0;
            inuse_d = '0;
            failed_d = 1'b0;
            strobe_d = 1'b1;
            rsp_d = mpsm_pkg::ack(mpsm_pkg::ST_OK);
          end
          mpsm_pkg::OP_ADD: begin
            if (!cmd_q.sym_ok || failed_q) begin
              strobe_d = 1'b1;
              rsp_d = mpsm_pkg::ack(failed_q ? mpsm_pkg::ST_FULL : mpsm_pkg::ST_OK);
            end
          end
          mpsm_pkg::OP_END: begin
            node_d = cursor_q;
            cursor_d = '0;
            if (failed_q) begin
              failed_d = 1'b0;
              strobe_d = 1'b1;
              rsp_d = mpsm_pkg::ack(mpsm_pkg::ST_FULL);
            end else if (cursor_q == '0 || inuse_q[cmd_q.req.pattern_id]) begin
              strobe_d = 1'b1;
              rsp_d = mpsm_pkg::ack(mpsm_pkg::ST_OK);
            end else begin
              inuse_d[cmd_q.req.pattern_id] = 1'b1;
            end
          end
          mpsm_pkg::OP_BUILD: begin
            bhead_d = '0;
            btail_d = 11'd1;
            bfs_we = 1'b1;
            bfs_wa = '0;
            bfs_wd = '0;
          end
          mpsm_pkg::OP_MATCH: begin
            count_d = '0;
            capped_d = 1'b0;
            node_d = mstart;
            if (!cmd_q.sym_ok) begin
              match_d = '0;
              strobe_d = 1'b1;
              rsp_d = mpsm_pkg::ack(mpsm_pkg::ST_OK);
            end
          end
          default: begin
            strobe_d = 1'b1;
            rsp_d = mpsm_pkg::ack(mpsm_pkg::ST_OK);
          end
        endcase
      end
      mpsm_pkg::S_ADD: begin
        if (add_nxt != '0) begin
          cursor_d = add_nxt;
          strobe_d = 1'b1;
          rsp_d = mpsm_pkg::ack(mpsm_pkg::ST_OK);
        end else if (ncount_q == 11'(mpsm_pkg::Nodes)
                     || cur_depth >= 11'(mpsm_pkg::MaxLine)) begin
          failed_d = 1'b1;
          strobe_d = 1'b1;
          rsp_d = mpsm_pkg::ack(mpsm_pkg::ST_FULL);
        end else begin
          child_we = 1'b1;
          child_wa = cursor_q;
          child_wd = child_rd;
          child_wd[cmd_q.req.symbol] = ncount_q[mpsm_pkg::NodeW-1:0];
          depth_we = 1'b1;
          head_we = 1'b1;
          fail_we = 1'b1;
          fail_wa = ncount_q[mpsm_pkg::NodeW-1:0];
        end
      end
      mpsm_pkg::S_ADD_NEW: begin
        child_we = 1'b1;
        child_wa = ncount_q[mpsm_pkg::NodeW-1:0];
        cursor_d = ncount_q[mpsm_pkg::NodeW-1:0];
        ncount_d = ncount_q + 11'd1;
        strobe_d = 1'b1;
        rsp_d = mpsm_pkg::ack(mpsm_pkg::ST_OK);
      end
      mpsm_pkg::S_END: begin
        plen_we = 1'b1;
        dup_we = 1'b1;
        if (head_rd == '0) begin
          head_we = 1'b1;
          head_wa = node_q;
          head_wd = id_plus;
          strobe_d = 1'b1;
          rsp_d = mpsm_pkg::ack(mpsm_pkg::ST_OK);
        end else begin
          ptr_d = 8'(head_rd - 9'd1);
        end
      end
      mpsm_pkg::S_END_RD: begin
        dup_ra = ptr_q;
      end
      mpsm_pkg::S_END_CHK: begin
        if (dup_rd != '0) begin
          ptr_d = 8'(dup_rd - 9'd1);
        end else begin
          dup_we = 1'b1;
          dup_wa = ptr_q;
          dup_wd = id_plus;
          strobe_d = 1'b1;
          rsp_d = mpsm_pkg::ack(mpsm_pkg::ST_OK);
        end
      end
      mpsm_pkg::S_B_POP: begin
        if (bhead_q == btail_q) begin
          strobe_d = 1'b1;
          rsp_d = mpsm_pkg::ack(mpsm_pkg::ST_OK);
        end else begin
          bhead_d = bhead_q + 11'd1;
        end
      end
      mpsm_pkg::S_B_U: begin
        u_d = bfs_rd;
        child_ra = bfs_rd;
        fail_ra = bfs_rd;
      end
      mpsm_pkg::S_B_ROW: begin
        row_d = child_rd;
        failu_d = fail_rd;
        chr_d = '0;
      end
      mpsm_pkg::S_B_C: begin
        if (chr_q != 5'(mpsm_pkg::Alpha)) begin
          if (bc_v == '0) begin
            chr_d = chr_q + 5'd1;
          end else if (u_q == '0) begin
            fail_we = 1'b1;
            fail_wa = bc_v;
            fail_wd = '0;
            if (btail_q < 11'(mpsm_pkg::Nodes)) begin
              bfs_we = 1'b1;
              bfs_wd = bc_v;
              btail_d = btail_q + 11'd1;
            end
            chr_d = chr_q + 5'd1;
          end else begin
            v_d = bc_v;
            node_d = failu_q;
          end
        end
      end
      mpsm_pkg::S_B_FCHK: begin
        if (fchk_r != '0 || node_q == '0) begin
          fail_we = 1'b1;
          fail_wd = (fchk_r != v_q) ? fchk_r : '0;
          if (btail_q < 11'(mpsm_pkg::Nodes)) begin
            bfs_we = 1'b1;
            btail_d = btail_q + 11'd1;
          end
          chr_d = chr_q + 5'd1;
        end else begin
          node_d = fail_rd;
        end
      end
      mpsm_pkg::S_M_CHK: begin
        if (chk_nxt != '0) begin
          node_d = chk_nxt;
          match_d = chk_nxt;
        end else if (node_q == '0) begin
          match_d = '0;
        end else begin
          node_d = fail_rd;
        end
      end
      mpsm_pkg::S_M_H: begin
        h_d = head_rd;
        failt_d = fail_rd;
      end
      mpsm_pkg::S_M_LIST: begin
        if (h_q == '0) begin
          node_d = failt_q;
        end else if (count_q == 7'(mpsm_pkg::MaxReports)) begin
          capped_d = 1'b1;
        end else begin
          ptr_d = h_id;
        end
      end
      mpsm_pkg::S_M_EMIT: begin
        // hold one report back so the final one can carry last
        if (count_q != '0) begin
          strobe_d = 1'b1;
          rsp_d = pend_q;
          rsp_d.last = 1'b0;
        end
        pend_d = rep;
        count_d = count_q + 7'd1;
        h_d = dup_rd;
      end
      mpsm_pkg::S_M_FIN: begin
        strobe_d = 1'b1;
        if (count_q == '0) begin
          rsp_d = mpsm_pkg::ack(mpsm_pkg::ST_OK);
        end else begin
          rsp_d = pend_q;
          rsp_d.last = 1'b1;
          rsp_d.status = capped_q ? mpsm_pkg::ST_CAP : mpsm_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  logic [mpsm_pkg::IdW-1:0] plen_wa;
  assign plen_wa = cmd_q.req.pattern_id;

  always_ff @(posedge clk_i) begin
    if (child_we) child_mem[child_wa] <= child_wd;
    child_rd <= child_mem[child_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    fail_rd <= fail_mem[fail_ra];
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (depth_we) depth_mem[depth_wa] <= depth_wd;
    depth_rd <= depth_mem[depth_ra];
  end

  always_ff @(posedge clk_i) begin
    if (dup_we) dup_mem[dup_wa] <= dup_wd;
    dup_rd <= dup_mem[dup_ra];
  end

  always_ff @(posedge clk_i) begin
    if (plen_we) plen_mem[plen_wa] <= plen_wd;
    plen_rd <= plen_mem[plen_ra];
  end

  always_ff @(posedge clk_i) begin
    if (bfs_we) bfs_mem[bfs_wa] <= bfs_wd;
    bfs_rd <= bfs_mem[bfs_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpsm_pkg::S_RST;
      cursor_q <= '0;
      match_q <= '0;
      ncount_q <= 11'd1;
      failed_q <= 1'b0;
      inuse_q <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cursor_q <= cursor_d;
      match_q <= match_d;
      ncount_q <= ncount_d;
      failed_q <= failed_d;
      inuse_q <= inuse_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    node_q <= node_d;
    u_q <= u_d;
    v_q <= v_d;
    failu_q <= failu_d;
    failt_q <= failt_d;
    ptr_q <= ptr_d;
    chr_q <= chr_d;
    row_q <= row_d;
    bhead_q <= bhead_d;
    btail_q <= btail_d;
    h_q <= h_d;
    count_q <= count_d;
    capped_q <= capped_d;
    pend_q <= pend_d;
    rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;
  assign rsp_strobe_o = strobe_q;

endmodule
`default_nettype wire

>>> sv/multi_pattern_string_matcher_unit.sv
`default_nettype none
// aho-corasick matcher over lower-case letters, one command request at a time
// input: a request is taken when start is high and busy is low; a two-entry
// queue lets up to two requests wait while the engine works on earlier ones
// commands: clear, add pattern symbol, end pattern, build failure links, match
// output: each result is shown for one cycle with rsp_strobe_o; there is no
// backpressure, every request gives one or more results, the final one with last
// config: num_rows is written through the cfg channel, always ready
// each request runs as a sequence of states: an add reads the current row and
// may write a new node; an end walks the ids already at that node
// match: follows failure links, then the output chain and its reports; a letter
// outside the alphabet gives a single result with no reports; every step
// is one registered read of the node memories, so the lookups set the rate
// build: visits the nodes in breadth-first order, each letter of each node, and
// follows failure links for the children of non-root nodes
// reset: the engine first zeroes the root row, then takes requests;
// the trie is empty and num_rows is zero
module multi_pattern_string_matcher_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire mpsm_pkg::req_t              req_i,
  output mpsm_pkg::rsp_t                   rsp_o,
  output logic                             rsp_strobe_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [mpsm_pkg::LineW-1:0]  cfg_data_i
);

  mpsm_pkg::qhead_t           head;
  logic                       pop;
  logic [mpsm_pkg::LineW-1:0] num_rows_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= '0;
    end else if (cfg_valid_i) begin
      num_rows_q <= cfg_data_i;
    end
  end

  mpsm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .head_o (head),
    .pop_i  (pop)
  );

  mpsm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .num_rows_i   (num_rows_q),
    .rsp_o        (rsp_o),
    .rsp_strobe_o (rsp_strobe_o)
  );

endmodule
`default_nettype wire
